// ===== design/cfa_pkg.sv =====
// cfa_pkg: shared constants, codes and types for the contiguous frame allocator.
// Used by every design file but cfa_ram; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

  // Table geometry
  localparam int FRAMES   = 1024;
  localparam int REF_BITS = 8;
  localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Field widths of the request and result
  localparam int FUNC_W = 2;
  localparam int SF_W   = 10;
  localparam int CNT_W  = 11;
  localparam int PROT_W = 2;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 10;

  // Counter width: holds a request count, the table size and a raw start frame
  localparam int FR1_W  = $clog2(FRAMES + 1);
  localparam int LEFT_W = (FR1_W > CNT_W) ? FR1_W : CNT_W;

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_FIND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_MAP  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REL  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZEROREF = 2'd2;

  // One table entry as stored in the frame RAM
  typedef struct packed {
    logic                mapped;
    logic [PROT_W-1:0]   prot;
    logic [REF_BITS-1:0] refc;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic clr;       // clearing sweep, one entry a cycle
    logic load;      // capture a request
    logic red;       // reduce start frame by FRAMES
    logic start;     // set up the walk address
    logic run;       // walk: issue reads, process returned entries
    logic out_load;  // move result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic red_ge;
    logic finish;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/cfa_if.sv =====
// cfa_in_if / cfa_out_if: valid-ready channels for requests and results.
// Depends on cfa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cfa_in_if;
  logic                       valid;
  logic                       ready;
  logic [cfa_pkg::FUNC_W-1:0] func;
  logic [cfa_pkg::SF_W-1:0]   start_frame;
  logic [cfa_pkg::CNT_W-1:0]  count;
  logic [cfa_pkg::PROT_W-1:0] protect;

  modport source (output valid, func, start_frame, count, protect, input ready);
  modport sink   (input valid, func, start_frame, count, protect, output ready);
endinterface

interface cfa_out_if;
  logic                       valid;
  logic                       ready;
  logic [cfa_pkg::STAT_W-1:0] status;
  logic [cfa_pkg::FIDX_W-1:0] frame_index;

  modport source (output valid, status, frame_index, input ready);
  modport sink   (input valid, status, frame_index, output ready);
endinterface

`default_nettype wire

// ===== design/cfa_ram.sv =====
// cfa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/cfa_datapath.sv =====
// cfa_datapath: frame table RAM, walk address and counters, entry update logic,
// result and output registers. Depends on cfa_pkg and cfa_ram.
`timescale 1ns / 1ps
`default_nettype none

module cfa_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cfa_pkg::cmd_t              cmd,
  output cfa_pkg::sts_t                   sts,
  input  wire logic [cfa_pkg::FUNC_W-1:0] in_func,
  input  wire logic [cfa_pkg::SF_W-1:0]   in_start_frame,
  input  wire logic [cfa_pkg::CNT_W-1:0]  in_count,
  input  wire logic [cfa_pkg::PROT_W-1:0] in_protect,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [cfa_pkg::STAT_W-1:0]      out_status,
  output logic [cfa_pkg::FIDX_W-1:0]      out_frame_index
);
  import cfa_pkg::*;

  logic [FUNC_W-1:0] func_r;
  logic [PROT_W-1:0] prot_r;
  logic [CNT_W-1:0]  need_r;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [LEFT_W-1:0] red_r, red_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt, addr_inc;
  logic [IDX_W-1:0]  s1_addr_r, s1_addr_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt, run_inc;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [FIDX_W-1:0] res_frame_r, res_frame_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [FIDX_W-1:0] out_frame_r;

  logic              issue, proc, hit_found, hit_zero, need_ok;
  logic [LEFT_W-1:0] found_at;
  logic [REF_BITS-1:0] ref_inc, ref_dec;
  entry_t            rd_entry, wr_entry;
  logic              we;
  logic [IDX_W-1:0]  waddr;

  cfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (addr_r),
    .rdata (rd_entry)
  );

  assign addr_inc = (addr_r == IDX_W'(FRAMES - 1)) ? '0 : addr_r + 1'b1;
  assign run_inc  = run_r + 1'b1;
  assign ref_inc  = (rd_entry.refc == REF_MAX) ? rd_entry.refc : rd_entry.refc + 1'b1;
  assign ref_dec  = rd_entry.refc - 1'b1;
  assign found_at = LEFT_W'(s1_addr_r) + LEFT_W'(1) - LEFT_W'(need_r);
  assign need_ok  = (in_count != '0) && (LEFT_W'(in_count) <= LEFT_W'(FRAMES));
  assign issue    = cmd.run && (left_r != '0);
  assign proc     = cmd.run && s1_valid_r;

  // entry processing and table writes
  always_comb begin
    we        = 1'b0;
    waddr     = s1_addr_r;
    wr_entry  = rd_entry;
    hit_found = 1'b0;
    hit_zero  = 1'b0;
    run_nxt   = run_r;
    if (cmd.clr) begin
      we       = 1'b1;
      waddr    = addr_r;
      wr_entry = '0;
    end else if (cmd.load) begin
      run_nxt = '0;
    end else if (proc) begin
      case (func_r)
        FN_FIND: begin
          if (rd_entry.mapped) begin
            run_nxt = '0;
          end else begin
            run_nxt   = run_inc;
            hit_found = (run_inc == need_r);
          end
        end
        FN_MAP: begin
          we              = 1'b1;
          wr_entry.mapped = 1'b1;
          wr_entry.prot   = rd_entry.prot | prot_r;
          wr_entry.refc   = ref_inc;
        end
        FN_REL: begin
          if (rd_entry.refc == '0) begin
            hit_zero = 1'b1;
          end else begin
            we = 1'b1;
            if (ref_dec == '0) begin
              wr_entry = '0;
            end else begin
              wr_entry.refc = ref_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // walk address, counters, result
  always_comb begin
    addr_nxt       = addr_r;
    left_nxt       = left_r;
    red_nxt        = red_r;
    s1_addr_nxt    = s1_addr_r;
    s1_valid_nxt   = issue;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    if (cmd.clr) begin
      addr_nxt = addr_inc;
    end
    if (cmd.load) begin
      red_nxt = LEFT_W'(in_start_frame);
      case (in_func)
        FN_FIND:         left_nxt = need_ok ? LEFT_W'(FRAMES) : '0;
        FN_MAP, FN_REL:  left_nxt = LEFT_W'(in_count);
        default:         left_nxt = '0;
      endcase
    end
    if (cmd.red) begin
      red_nxt = red_r - LEFT_W'(FRAMES);
    end
    if (cmd.start) begin
      addr_nxt = (func_r == FN_FIND) ? '0 : red_r[IDX_W-1:0];
    end
    if (issue) begin
      addr_nxt    = addr_inc;
      left_nxt    = left_r - 1'b1;
      s1_addr_nxt = addr_r;
    end
    if (sts.finish) begin
      if (hit_found) begin
        res_status_nxt = ST_OK;
        res_frame_nxt  = found_at[FIDX_W-1:0];
      end else if (hit_zero) begin
        res_status_nxt = ST_ZEROREF;
        res_frame_nxt  = FIDX_W'(s1_addr_r);
      end else begin
        res_status_nxt = (func_r == FN_FIND) ? ST_NOFIT : ST_OK;
        res_frame_nxt  = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.clr_last = (addr_r == IDX_W'(FRAMES - 1));
  assign sts.red_ge   = (red_r >= LEFT_W'(FRAMES));
  assign sts.finish   = cmd.run && (hit_found || hit_zero || (left_r == '0 && !s1_valid_r));
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      addr_r      <= addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      prot_r <= in_protect;
      need_r <= in_count;
    end
    left_r       <= left_nxt;
    red_r        <= red_nxt;
    s1_addr_r    <= s1_addr_nxt;
    run_r        <= run_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_frame_r  <= res_frame_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_frame_index = out_frame_r;

endmodule

`default_nettype wire

// ===== design/cfa_ctrl.sv =====
// cfa_ctrl: sequencing state machine (clear sweep, start reduction, walk, hand-off).
// Depends on cfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cfa_pkg::sts_t sts,
  output cfa_pkg::cmd_t      cmd
);
  import cfa_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (sts.red_ge) begin
          cmd.red = 1'b1;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (sts.finish) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/contiguous_frame_allocator.sv =====
// Sequence: start set-up (plus start_frame reduction by FRAMES when FRAMES < 1024),
//   then a walk of one table entry a cycle (count entries for map, up to count for release,
//   up to FRAMES for find), then the move to the output register. Rate is set by the single RAM read port.
// Throughput: one request at a time, next request taken once the result is latched.
// Reset (rst_n low, synchronous): a clearing sweep writes every entry to
//   free/zero; requests are refused until it ends.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_frame_allocator (
  input  wire logic clk,
  input  wire logic rst_n,
  cfa_in_if.sink    in_ch,
  cfa_out_if.source out_ch
);
  import cfa_pkg::*;

  // control/status between the sequencer and the datapath
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencer: clear sweep, start-frame reduction, walk, result hand-off
  cfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: frame table RAM, read pipeline of one stage, entry update, output register.
  // Reads are issued one a cycle; the returned entry is processed, and for map/release
  // written back, the next cycle while the following read is in flight.
  cfa_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_ch.func),
    .in_start_frame  (in_ch.start_frame),
    .in_count        (in_ch.count),
    .in_protect      (in_ch.protect),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_frame_index (out_ch.frame_index)
  );

  // ready is independent of the output side: a held result does not block acceptance
  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

// ===== design/cfa_checker.sv =====
// cfa_checker: port-level assertions for contiguous_frame_allocator, plus its bind.
// Depends on cfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfa_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [cfa_pkg::STAT_W-1:0] out_status,
  input wire logic [cfa_pkg::FIDX_W-1:0] out_frame_index
);
  import cfa_pkg::*;

  // clearing sweep follows reset: nothing accepted
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request accepted straight after reset");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high the cycle after an accepted request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOFIT |-> out_frame_index == '0)
    else $error("failed find with non-zero frame index");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOFIT ||
                   out_status == ST_ZEROREF))
    else $error("unknown status code");

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_frame_index (out_ch.frame_index)
);

`default_nettype wire

// ===== verif/contiguous_frame_allocator_tb.sv =====
// contiguous_frame_allocator_tb: self-checking bench for the first-fit frame allocator.
// Needs cfa_pkg and the cfa_in_if / cfa_out_if channels from the design folder.
// A shadow frame table predicts each result; directed cases run first, then random traffic.
`timescale 1ns / 1ps

module contiguous_frame_allocator_tb;
  import cfa_pkg::*;

  // func value with no operation behind it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int RANDOM_ITEMS = 300;
  localparam int SAT_MAPS     = 258;        // enough visits to pin a count at its maximum
  localparam int REPORT_MAX   = 10;
  localparam int IDLE_PCT     = 15;
  localparam int MAX_COUNT    = (1 << CNT_W) - 1;
  localparam int LAST_FRAME   = FRAMES - 1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] frame_index;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cfa_in_if  in_ch ();
  cfa_out_if out_ch ();

  contiguous_frame_allocator dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the frame table
  logic                frame_busy [FRAMES];
  logic [REF_BITS-1:0] frame_refs [FRAMES];
  logic [PROT_W-1:0]   frame_prot [FRAMES];

  alloc_result_t pending_results [$];   // oldest expectation at the front
  int            live_start [$];        // runs mapped by the random part, awaiting release
  int            live_len [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit no_idle        = 1'b0;            // set for the stretch with no stalls on either side

  // ---------------------------------------------------------------------------
  // Predictor: applies one request to the shadow table and returns its result.
  // ---------------------------------------------------------------------------
  function automatic alloc_result_t predict_allocation(
    input logic [FUNC_W-1:0] op,
    input logic [SF_W-1:0]   first,
    input logic [CNT_W-1:0]  n,
    input logic [PROT_W-1:0] prot
  );
    alloc_result_t res;
    int            idx;
    int            run;
    int            f;
    int            i;
    res.status      = ST_OK;
    res.frame_index = '0;
    idx             = int'(first) % FRAMES;
    case (op)
      FN_FIND: begin
        // lowest start of n free frames; the run may not wrap
        res.status = ST_NOFIT;
        if (n != 0 && int'(n) <= FRAMES) begin
          run = 0;
          f   = 0;
          while (f < FRAMES && res.status != ST_OK) begin
            if (!frame_busy[f]) begin
              run++;
              if (run == int'(n)) begin
                res.status      = ST_OK;
                res.frame_index = FIDX_W'(f + 1 - run);
              end
            end else begin
              run = 0;
            end
            f++;
          end
        end
      end
      FN_MAP: begin
        for (i = 0; i < int'(n); i++) begin
          frame_prot[idx] = frame_prot[idx] | prot;
          if (frame_refs[idx] != REF_MAX) frame_refs[idx] = frame_refs[idx] + 1'b1;
          frame_busy[idx] = 1'b1;
          idx = (idx + 1) % FRAMES;
        end
      end
      FN_REL: begin
        // stops at the first zero count; earlier frames keep their decrement
        i = 0;
        while (i < int'(n) && res.status == ST_OK) begin
          if (frame_refs[idx] == '0) begin
            res.status      = ST_ZEROREF;
            res.frame_index = FIDX_W'(idx);
          end else begin
            frame_refs[idx] = frame_refs[idx] - 1'b1;
            if (frame_refs[idx] == '0) begin
              frame_busy[idx] = 1'b0;
              frame_prot[idx] = '0;
            end
            idx = (idx + 1) % FRAMES;
          end
          i++;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s differs: expected %0d, got %0d", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes inputs on the falling edge, idles now and then,
  // holds the request until the block takes it, then records the prediction.
  // valid stays high after acceptance so that back-to-back requests need no
  // second assignment in one step; end_requests lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_request(
    input  logic [FUNC_W-1:0] op,
    input  logic [SF_W-1:0]   first,
    input  logic [CNT_W-1:0]  n,
    input  logic [PROT_W-1:0] prot,
    output alloc_result_t     predicted
  );
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= op;
    in_ch.start_frame <= first;
    in_ch.count       <= n;
    in_ch.protect     <= prot;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_allocation(op, first, n, prot);
    pending_results.push_back(predicted);
  endtask

  task automatic end_requests();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls, none during the quiet stretch
  always @(negedge clk)
    out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result (status)", -1, int'(out_ch.status));
      end else begin
        want = pending_results.pop_front();
        if (want.status != out_ch.status)
          report_mismatch("status", int'(want.status), int'(out_ch.status));
        if (want.frame_index != out_ch.frame_index)
          report_mismatch("frame_index", int'(want.frame_index),
                          int'(out_ch.frame_index));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Find on an empty table: zero count, whole table, oversize counts;
  // zero-count map and release; the unused func value; release of a free frame.
  task automatic test_find_limits();
    alloc_result_t r;
    send_request(FN_FIND, '0, '0, '0, r);
    send_request(FN_FIND, '0, CNT_W'(FRAMES), '0, r);
    send_request(FN_FIND, '1, CNT_W'(FRAMES + 1), '1, r);
    send_request(FN_FIND, '0, CNT_W'(MAX_COUNT), '0, r);
    send_request(FN_FIND, '0, 11'd1, '0, r);
    send_request(FN_REL, '0, '0, '0, r);
    send_request(FN_MAP, '0, '0, 2'd3, r);
    send_request(FN_UNUSED, '1, '1, '1, r);
    send_request(FN_REL, 10'd5, 11'd3, '0, r);
  endtask

  // Wrapping map and release, partial release stopped by a zero count,
  // walks longer than the table, all-ones start and count.
  task automatic test_map_release_wrap();
    alloc_result_t r;
    send_request(FN_MAP, SF_W'(LAST_FRAME), 11'd2, 2'd0, r);   // protect zero still maps
    send_request(FN_FIND, '0, 11'd1, '0, r);
    send_request(FN_FIND, '0, CNT_W'(FRAMES - 2), '0, r);
    send_request(FN_FIND, '0, CNT_W'(FRAMES - 1), '0, r);
    send_request(FN_MAP, SF_W'(LAST_FRAME), 11'd2, 2'd3, r);
    send_request(FN_REL, SF_W'(LAST_FRAME), 11'd2, '0, r);
    // frees the two wrapped frames, then meets frame 1 with no references
    send_request(FN_REL, SF_W'(LAST_FRAME), 11'd3, '0, r);
    send_request(FN_FIND, '0, CNT_W'(FRAMES), '0, r);
    send_request(FN_MAP, '0, CNT_W'(FRAMES + 5), 2'd2, r);      // first five frames twice
    send_request(FN_FIND, '0, 11'd1, '0, r);
    send_request(FN_REL, '0, CNT_W'(FRAMES), '0, r);
    send_request(FN_FIND, '0, 11'd2, '0, r);
    send_request(FN_REL, '0, 11'd6, '0, r);
    send_request(FN_MAP, '1, '1, 2'd1, r);
    send_request(FN_REL, '1, '1, '0, r);
  endtask

  // Free frames only at both ends: the wrapped run must not be found
  task automatic test_find_no_wrap();
    alloc_result_t r;
    send_request(FN_MAP, 10'd2, CNT_W'(FRAMES - 4), 2'd1, r);
    send_request(FN_FIND, '0, 11'd3, '0, r);
    send_request(FN_FIND, '0, 11'd2, '0, r);
    send_request(FN_REL, 10'd2, CNT_W'(FRAMES - 4), '0, r);
  endtask

  // Drive two frames across the end of the table past the top of their
  // reference counts, then step one back down; they stay mapped afterwards.
  task automatic test_ref_saturation();
    alloc_result_t r;
    int            i;
    for (i = 0; i < SAT_MAPS; i++)
      send_request(FN_MAP, SF_W'(LAST_FRAME), 11'd2, PROT_W'($urandom_range(3)), r);
    send_request(FN_REL, SF_W'(LAST_FRAME), 11'd2, '0, r);
  endtask

  // Mostly find-then-map allocations and releases of live runs, with shared
  // runs, double releases and random noise mixed in.
  task automatic test_random_traffic();
    alloc_result_t       r;
    int                  sent;
    int                  pick;
    int                  k;
    int                  at;
    int                  len;
    logic [FUNC_W-1:0]   op;
    logic [CNT_W-1:0]    n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = (sent >= 80 && sent < 160);
      pick    = $urandom_range(99);
      if (pick < 40) begin
        // allocate: find a run, then map it
        len = ($urandom_range(19) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 24);
        send_request(FN_FIND, SF_W'($urandom), CNT_W'(len), PROT_W'($urandom), r);
        sent++;
        if (r.status == ST_OK) begin
          at = int'(r.frame_index);
          send_request(FN_MAP, SF_W'(at), CNT_W'(len), PROT_W'($urandom_range(1, 3)), r);
          sent++;
          live_start.push_back(at);
          live_len.push_back(len);
        end
      end else if (pick < 70 && live_start.size() != 0) begin
        k = $urandom_range(live_start.size() - 1);
        send_request(FN_REL, SF_W'(live_start[k]), CNT_W'(live_len[k]), PROT_W'($urandom), r);
        sent++;
        // occasional double release, normally meets a zero count
        if ($urandom_range(9) == 0) begin
          send_request(FN_REL, SF_W'(live_start[k]), CNT_W'(live_len[k]), '0, r);
          sent++;
        end
        live_start.delete(k);
        live_len.delete(k);
      end else if (pick < 80 && live_start.size() != 0) begin
        // share a live run: map again, release it once more later
        k = $urandom_range(live_start.size() - 1);
        send_request(FN_MAP, SF_W'(live_start[k]), CNT_W'(live_len[k]),
                     PROT_W'($urandom), r);
        sent++;
        live_start.push_back(live_start[k]);
        live_len.push_back(live_len[k]);
      end else begin
        // noise; large counts only where they cannot clog the table for good
        op   = FUNC_W'($urandom_range(3));
        at   = $urandom_range(LAST_FRAME);
        pick = $urandom_range(99);
        if (op == FN_MAP)   len = $urandom_range(0, 48);
        else if (pick < 70) len = $urandom_range(0, 32);
        else if (pick < 95) len = $urandom_range(0, 1100);
        else                len = $urandom_range(0, MAX_COUNT);
        n = CNT_W'(len);
        send_request(op, SF_W'(at), n, PROT_W'($urandom), r);
        sent++;
        if (op == FN_MAP && len != 0) begin
          live_start.push_back(at);
          live_len.push_back(len);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int f;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FN_FIND;
    in_ch.start_frame = '0;
    in_ch.count       = '0;
    in_ch.protect     = '0;
    out_ch.ready      = 1'b0;
    for (f = 0; f < FRAMES; f++) begin
      frame_busy[f] = 1'b0;
      frame_refs[f] = '0;
      frame_prot[f] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the block runs its clearing sweep first; requests simply wait for ready
    test_find_limits();
    test_map_release_wrap();
    test_find_no_wrap();
    test_ref_saturation();
    test_random_traffic();
    end_requests();

    while (pending_results.size() != 0) @(posedge clk);
    // room for any stray result after the last one
    repeat (FRAMES + 8) @(posedge clk);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
design/cfa_pkg.sv
design/cfa_if.sv
design/cfa_ram.sv
design/cfa_datapath.sv
design/cfa_ctrl.sv
design/contiguous_frame_allocator.sv
design/cfa_checker.sv
verif/contiguous_frame_allocator_tb.sv
